// ----- rtl/assert_macros.svh -----
// Assertion helpers for the key resolver checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, sampled on the rising clock edge, disabled in reset.
`define CHK_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Concurrent assertion that also runs during reset.
`define CHK_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/drkr_pkg.sv -----
`default_nettype none

package drkr_pkg;

    localparam logic [1:0] KIND_PASS  = 2'd0;
    localparam logic [1:0] KIND_BLOCK = 2'd1;
    localparam logic [1:0] KIND_DONE  = 2'd2;
    localparam logic [1:0] KIND_FLUSH = 2'd3;

    localparam logic CFG_ENABLE  = 1'b0;
    localparam logic CFG_TIMEOUT = 1'b1;

    localparam logic [15:0] TIMEOUT_RESET = 16'd500;

    localparam logic REQ_KEY  = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    localparam int KEY_COUNT = 64;

    // Request decoded by the front stage.
    typedef enum logic [2:0] {
        OP_PASS,
        OP_TICK,
        OP_PRESS,
        OP_RELEASE,
        OP_HELD
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [5:0]  sw_addr;
        logic        is_dual_role;
        logic [31:0] deadline;
        logic [31:0] now_ms;
    } cmd_t;

endpackage

`default_nettype wire

// ----- rtl/drkr_front.sv -----
`default_nettype none

module drkr_front
    import drkr_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        enable,
    input  wire logic [15:0] timeout_ms,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        req_type,
    input  wire logic [5:0]  sw_addr,
    input  wire logic        is_dual_role,
    input  wire logic        pressed_now,
    input  wire logic        pressed_before,
    input  wire logic        injected,
    input  wire logic [31:0] now_ms,
    output logic             cmd_valid,
    input  wire logic        cmd_ready,
    output cmd_t             cmd
);

    cmd_t cmd_reg;
    logic valid_reg;
    op_t  op;

    always_comb begin
        if (req_type == REQ_TICK) begin
            op = OP_TICK;
        end else if (!enable || injected || (!pressed_now && !pressed_before)) begin
            op = OP_PASS;
        end else if (pressed_now && !pressed_before) begin
            op = OP_PRESS;
        end else if (!pressed_now) begin
            op = OP_RELEASE;
        end else begin
            op = OP_HELD;
        end
    end

    assign in_ready  = !valid_reg || cmd_ready;
    assign cmd_valid = valid_reg;
    assign cmd       = cmd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_valid && in_ready) begin
            cmd_reg.op           <= op;
            cmd_reg.sw_addr      <= sw_addr;
            cmd_reg.is_dual_role <= is_dual_role;
            cmd_reg.deadline     <= now_ms + {16'd0, timeout_ms};
            cmd_reg.now_ms       <= now_ms;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/drkr_back.sv -----
`default_nettype none

module drkr_back
    import drkr_pkg::*;
#(
    parameter int QUEUE_DEPTH = 8
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cmd_valid,
    output logic             cmd_ready,
    input  wire cmd_t        cmd,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_kind,
    output logic [5:0]       m_flush_addr,
    output logic             m_use_alternate,
    output logic             m_still_held,
    output logic             m_last
);

    localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DECIDE,
        ST_EMIT,
        ST_VERDICT
    } state_t;

    state_t      state_reg;
    cmd_t        cur_reg;
    logic [5:0]  q_addr_reg  [QUEUE_DEPTH];
    logic [31:0] q_dl_reg    [QUEUE_DEPTH];
    logic        q_dual_reg  [QUEUE_DEPTH];
    logic [CW-1:0] count_reg;
    logic [KEY_COUNT-1:0] role_reg;
    logic [CW-1:0] idx_reg;
    logic          found_reg;
    logic [CW-1:0] pos_reg;
    logic          full_phase_reg;
    logic          mode_alt_reg;
    logic          mode_held_reg;
    logic [1:0]    ok_reg;
    logic          oalt_reg;

    logic          outv_reg;
    logic [1:0]    okind_reg;
    logic [5:0]    oaddr_reg;
    logic          oalt_o_reg;
    logic          oheld_reg;
    logic          olast_reg;

    logic          out_free;
    logic          out_load;
    logic [31:0]   diff;
    logic          role_hit;
    logic [QW-1:0] idx_lo;

    assign out_free  = !outv_reg || m_ready;
    assign out_load  = out_free && (state_reg inside {ST_EMIT, ST_VERDICT});
    assign cmd_ready = (state_reg == ST_IDLE);
    assign diff      = cur_reg.now_ms - q_dl_reg[0];
    assign idx_lo    = idx_reg[QW-1:0];
    assign role_hit  = role_reg[cur_reg.sw_addr];

    assign m_valid         = outv_reg;
    assign m_kind          = okind_reg;
    assign m_flush_addr    = oaddr_reg;
    assign m_use_alternate = oalt_o_reg;
    assign m_still_held    = oheld_reg;
    assign m_last          = olast_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            role_reg  <= '0;
            outv_reg  <= 1'b0;
        end else begin
            if (out_load) begin
                outv_reg <= 1'b1;
            end else if (m_ready) begin
                outv_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (cmd_valid) begin
                        cur_reg        <= cmd;
                        idx_reg        <= '0;
                        found_reg      <= 1'b0;
                        full_phase_reg <= 1'b0;
                        oalt_reg       <= 1'b0;
                        case (cmd.op)
                            OP_RELEASE, OP_HELD: state_reg <= ST_SEARCH;
                            default:             state_reg <= ST_DECIDE;
                        endcase
                    end
                end
                ST_SEARCH: begin
                    if (idx_reg == count_reg) begin
                        state_reg <= ST_DECIDE;
                    end else if (q_addr_reg[idx_lo] == cur_reg.sw_addr) begin
                        found_reg <= 1'b1;
                        pos_reg   <= idx_reg;
                        state_reg <= ST_DECIDE;
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                ST_DECIDE: begin
                    // pick next flush or the verdict
                    case (cur_reg.op)
                        OP_TICK: begin
                            ok_reg <= KIND_DONE;
                            if (count_reg != '0 && !q_dual_reg[0]) begin
                                mode_alt_reg <= 1'b0; mode_held_reg <= 1'b1;
                                state_reg <= ST_EMIT;
                            end else if (count_reg != '0 && diff != 32'd0 && !diff[31]) begin
                                mode_alt_reg <= 1'b1; mode_held_reg <= 1'b1;
                                state_reg <= ST_EMIT;
                            end else begin
                                state_reg <= ST_VERDICT;
                            end
                        end
                        OP_PRESS: begin
                            if (!full_phase_reg && count_reg == '0
                                && !cur_reg.is_dual_role) begin
                                ok_reg    <= KIND_PASS;
                                state_reg <= ST_VERDICT;
                            end else if (count_reg == CW'(QUEUE_DEPTH) && !full_phase_reg) begin
                                full_phase_reg <= 1'b1;
                                mode_alt_reg <= 1'b0; mode_held_reg <= 1'b1;
                                state_reg <= ST_EMIT;
                            end else if (full_phase_reg && count_reg != '0
                                         && !q_dual_reg[0]) begin
                                mode_alt_reg <= 1'b0; mode_held_reg <= 1'b1;
                                state_reg <= ST_EMIT;
                            end else begin
                                q_addr_reg[count_reg[QW-1:0]] <= cur_reg.sw_addr;
                                q_dl_reg[count_reg[QW-1:0]]   <= cur_reg.deadline;
                                q_dual_reg[count_reg[QW-1:0]] <= cur_reg.is_dual_role;
                                count_reg <= count_reg + 1'b1;
                                ok_reg    <= KIND_BLOCK;
                                state_reg <= ST_VERDICT;
                            end
                        end
                        OP_RELEASE: begin
                            ok_reg <= KIND_PASS;
                            if (found_reg) begin
                                mode_alt_reg  <= (pos_reg != '0);
                                mode_held_reg <= (pos_reg != '0);
                                state_reg <= ST_EMIT;
                            end else begin
                                state_reg <= ST_VERDICT;
                            end
                        end
                        OP_HELD: begin
                            if (found_reg) begin
                                ok_reg <= KIND_BLOCK;
                            end else begin
                                ok_reg   <= KIND_PASS;
                                oalt_reg <= cur_reg.is_dual_role && role_hit;
                            end
                            state_reg <= ST_VERDICT;
                        end
                        default: begin
                            ok_reg    <= KIND_PASS;
                            state_reg <= ST_VERDICT;
                        end
                    endcase
                end
                ST_EMIT: begin
                    if (out_free) begin
                        okind_reg  <= KIND_FLUSH;
                        oaddr_reg  <= q_addr_reg[0];
                        oalt_o_reg <= mode_alt_reg && q_dual_reg[0];
                        oheld_reg  <= mode_held_reg;
                        olast_reg  <= 1'b0;
                        if (q_dual_reg[0]) begin
                            role_reg[q_addr_reg[0]] <= mode_alt_reg;
                        end
                        for (int i = 0; i + 1 < QUEUE_DEPTH; i++) begin
                            q_addr_reg[i] <= q_addr_reg[i+1];
                            q_dl_reg[i]   <= q_dl_reg[i+1];
                            q_dual_reg[i] <= q_dual_reg[i+1];
                        end
                        count_reg <= count_reg - 1'b1;
                        if (cur_reg.op == OP_RELEASE) begin
                            if (pos_reg != '0) begin
                                pos_reg <= pos_reg - 1'b1;
                                mode_alt_reg  <= (pos_reg != CW'(1));
                                mode_held_reg <= (pos_reg != CW'(1));
                            end else begin
                                state_reg <= ST_VERDICT;
                            end
                        end else begin
                            state_reg <= ST_DECIDE;
                        end
                    end
                end
                ST_VERDICT: begin
                    if (out_free) begin
                        okind_reg  <= ok_reg;
                        oaddr_reg  <= 6'd0;
                        oalt_o_reg <= (ok_reg == KIND_PASS) && oalt_reg;
                        oheld_reg  <= 1'b0;
                        olast_reg  <= 1'b1;
                        state_reg  <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- rtl/dual_role_key_resolver.sv -----
// From accept to verdict a request passes the front register and the back end's IDLE,
//   DECIDE and VERDICT states; a release or held event first searches the queue one
//   entry at a time, each flush record passes through EMIT, and output stalls add to it.
// The back end takes one item at a time; its time per item is set by the sequential
//   queue search and by the flush records, one per step.
// Reset: synchronous active low; queue empty, all roles primary, enable 1, timeout 500.
`default_nettype none

module dual_role_key_resolver
    import drkr_pkg::*;
#(
    parameter int QUEUE_DEPTH = 8
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_req_type,
    input  wire logic [5:0]  s_sw_addr,
    input  wire logic        s_is_dual_role,
    input  wire logic        s_pressed_now,
    input  wire logic        s_pressed_before,
    input  wire logic        s_injected,
    input  wire logic [31:0] s_now_ms,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_kind,
    output logic [5:0]       m_flush_addr,
    output logic             m_use_alternate,
    output logic             m_still_held,
    output logic             m_last
);

    logic        enable_reg;
    logic [15:0] timeout_reg;
    logic        cmd_valid;
    logic        cmd_ready;
    cmd_t        cmd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg  <= 1'b1;
            timeout_reg <= TIMEOUT_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_ENABLE:  enable_reg  <= cfg_data[0];
                CFG_TIMEOUT: timeout_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    drkr_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .enable(enable_reg), .timeout_ms(timeout_reg),
        .in_valid(s_valid), .in_ready(s_ready),
        .req_type(s_req_type), .sw_addr(s_sw_addr),
        .is_dual_role(s_is_dual_role), .pressed_now(s_pressed_now),
        .pressed_before(s_pressed_before), .injected(s_injected),
        .now_ms(s_now_ms),
        .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd)
    );

    drkr_back #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
        .m_valid(m_valid), .m_ready(m_ready), .m_kind(m_kind),
        .m_flush_addr(m_flush_addr), .m_use_alternate(m_use_alternate),
        .m_still_held(m_still_held), .m_last(m_last)
    );

endmodule

`default_nettype wire

// ----- rtl/drkr_checker.sv -----
`default_nettype none
`include "assert_macros.svh"

module drkr_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [1:0] m_kind,
    input wire logic [5:0] m_flush_addr,
    input wire logic       m_still_held,
    input wire logic       m_last
);

    localparam logic [1:0] K_FLUSH = 2'd3;

    `CHK_ASSERT(a_valid_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid, "valid dropped")
    `CHK_ASSERT(a_last_verdict, aclk, aresetn, m_valid |-> (m_last == (m_kind != K_FLUSH)), "last mismatch")
    `CHK_ASSERT(a_verdict_clean, aclk, aresetn, m_valid && m_last |-> (m_flush_addr == 6'd0 && !m_still_held), "verdict fields")
    `CHK_ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn |=> !m_valid, "valid after reset")

endmodule

bind dual_role_key_resolver drkr_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .m_valid(m_valid), .m_ready(m_ready),
    .m_kind(m_kind), .m_flush_addr(m_flush_addr), .m_still_held(m_still_held),
    .m_last(m_last)
);

`default_nettype wire
